// ===== design/otc_pkg.sv =====
// Shared constants, control codes and controller/datapath bundles of the oven thermostat.
// Has no dependencies; the datapath, controller and top level refer to it by scoped names.
package otc_pkg;

    // Field widths of the stream beats and configuration registers.
    localparam int RAW_W    = 12;
    localparam int OFS_W    = 10;
    localparam int SP_W     = 10;
    localparam int INT_W    = 17;
    localparam int SAMPLE_W = 14;
    localparam int TEMP_W   = 12;
    localparam int MEAN_W   = 16;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;

    // Configuration port geometry and register indexes.
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam logic [1:0] REG_OFFSET   = 2'd0;
    localparam logic [1:0] REG_SETPOINT = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    // Reset value of the interval register and the saturation value of the tick counter.
    localparam logic [INT_W-1:0] INTERVAL_RESET = 17'd60000;
    localparam logic [INT_W-1:0] TICK_MAX       = 17'h1FFFF;

    // Item kinds carried on the input tuser bit.
    localparam logic FUNC_READING = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sample_load;
        logic short_rd;
        logic short_upd;
        logic sdiv_start;
        logic temp_upd;
        logic long_rd;
        logic long_upd;
        logic ldiv_start;
        logic mean_upd;
        logic out_load;
        logic tick;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic long_go;
    } t_sts;

endpackage

// ===== design/otc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the short and long averaging rings.
module otc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/otc_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for the rounded means.
// No package dependencies; instantiated by the thermostat datapath.
module otc_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // One trial subtraction per cycle; the dividend shifts out as quotient bits shift in.
    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        diff   = trial - {1'b0, r_den};
        fits   = (trial >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the arithmetic registers are loaded at start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== design/otc_dp.sv =====
// Thermostat datapath: averaging rings, running totals, shared divider, relay and outputs.
// Depends on otc_pkg, otc_ram and otc_div; driven by commands from otc_ctrl.
module otc_dp #(
    parameter int SHORT_DEPTH = 8,
    parameter int LONG_DEPTH  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  otc_pkg::t_cmd                        i_cmd,
    output otc_pkg::t_sts                        o_sts,
    input  logic [otc_pkg::RAW_W-1:0]            i_raw,
    input  logic signed [otc_pkg::OFS_W-1:0]     i_offset,
    input  logic [otc_pkg::SP_W-1:0]             i_setpoint,
    input  logic [otc_pkg::INT_W-1:0]            i_interval,
    output logic [otc_pkg::OUT_W-1:0]            o_result
);

    localparam int SAW  = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
    localparam int SFW  = $clog2(SHORT_DEPTH + 1);
    localparam int STW  = otc_pkg::SAMPLE_W + $clog2(SHORT_DEPTH);
    localparam int LAW  = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
    localparam int LFW  = $clog2(LONG_DEPTH + 1);
    localparam int LTW  = otc_pkg::TEMP_W + $clog2(LONG_DEPTH);
    localparam int NW   = (STW + 1 > LTW + 5) ? STW + 1 : LTW + 5;
    localparam int SDEN = 8 * SHORT_DEPTH;
    localparam int LDEN = 2 * LONG_DEPTH;
    localparam int DW   = $clog2(((SDEN > LDEN) ? SDEN : LDEN) + 1);
    localparam int SMW  = otc_pkg::SAMPLE_W;
    localparam int TW   = otc_pkg::TEMP_W;
    localparam int MW   = otc_pkg::MEAN_W;

    // Ring pointers, fill counts, totals and latched results.
    logic signed [SMW-1:0]  r_sample;
    logic [SAW-1:0]         r_swpos, n_swpos;
    logic [SFW-1:0]         r_sfill, n_sfill;
    logic signed [STW-1:0]  r_stotal, n_stotal;
    logic [LAW-1:0]         r_lwpos, n_lwpos;
    logic [LFW-1:0]         r_lfill, n_lfill;
    logic signed [LTW-1:0]  r_ltotal, n_ltotal;
    logic signed [MW-1:0]   r_lmean, n_lmean;
    logic                   r_reached, n_reached;
    logic                   r_relay, n_relay;
    logic [otc_pkg::INT_W-1:0] r_tick, n_tick;
    logic                   r_taken, n_taken;
    logic signed [TW-1:0]   r_temp;
    logic                   r_sneg;
    logic                   r_lneg;
    logic [otc_pkg::OUT_W-1:0] r_out;

    // Ring read data, divider interface and intermediate values.
    logic signed [SMW-1:0]  s_rdata;
    logic signed [TW-1:0]   l_rdata;
    logic signed [SMW-1:0]  s_old;
    logic signed [TW-1:0]   l_old;
    logic signed [STW-1:0]  s_new_ext, s_old_ext;
    logic signed [LTW-1:0]  l_new_ext, l_old_ext;
    logic [STW-1:0]         s_mag;
    logic [LTW-1:0]         l_mag;
    logic [NW-1:0]          s_num, l_num, div_num;
    logic [DW-1:0]          s_den, l_den, div_den;
    logic                   div_start;
    logic                   div_done;
    logic [NW-1:0]          div_quo;
    logic [TW-1:0]          q_temp;
    logic [MW-1:0]          q_mean;
    logic signed [TW-1:0]   temp_val;
    logic signed [TW-1:0]   sp_ext;
    logic signed [SMW-1:0]  sample_val;
    logic signed [SMW-1:0]  raw_ext;
    logic signed [SMW-1:0]  ofs_ext;

    otc_ram #(.WIDTH(SMW), .DEPTH(SHORT_DEPTH)) u_short_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.short_upd),
        .i_waddr (r_swpos),
        .i_wdata (r_sample),
        .i_re    (i_cmd.short_rd),
        .i_raddr (r_swpos),
        .o_rdata (s_rdata)
    );

    otc_ram #(.WIDTH(TW), .DEPTH(LONG_DEPTH)) u_long_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.long_upd),
        .i_waddr (r_lwpos),
        .i_wdata (r_temp),
        .i_re    (i_cmd.long_rd),
        .i_raddr (r_lwpos),
        .o_rdata (l_rdata)
    );

    otc_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Calibrated sample: raw reading plus the signed offset, both in quarter degrees.
    always_comb begin
        raw_ext    = SMW'(i_raw);
        ofs_ext    = i_offset;
        sample_val = raw_ext + ofs_ext;
    end

    // An entry not yet overwritten since reset is treated as zero.
    always_comb begin
        s_old     = (r_sfill == SFW'(SHORT_DEPTH)) ? s_rdata : '0;
        l_old     = (r_lfill == LFW'(LONG_DEPTH)) ? l_rdata : '0;
        s_new_ext = r_sample;
        s_old_ext = s_old;
        l_new_ext = r_temp;
        l_old_ext = l_old;
    end

    // Halves away from zero; T=|total|, n=fill: short (2T+4n)/(8n), long (32T+n)/(2n).
    always_comb begin
        s_mag     = r_stotal[STW-1] ? STW'(-r_stotal) : STW'(r_stotal);
        l_mag     = r_ltotal[LTW-1] ? LTW'(-r_ltotal) : LTW'(r_ltotal);
        s_den     = DW'({r_sfill, 3'b000});
        l_den     = DW'({r_lfill, 1'b0});
        s_num     = NW'({s_mag, 1'b0}) + NW'({r_sfill, 2'b00});
        l_num     = NW'({l_mag, 5'b00000}) + NW'(r_lfill);
        div_start = i_cmd.sdiv_start | i_cmd.ldiv_start;
        div_num   = i_cmd.ldiv_start ? l_num : s_num;
        div_den   = i_cmd.ldiv_start ? l_den : s_den;
    end

    // Restore the sign of the quotients.
    always_comb begin
        q_temp   = div_quo[TW-1:0];
        q_mean   = div_quo[MW-1:0];
        temp_val = r_sneg ? TW'(-q_temp) : TW'(q_temp);
        sp_ext   = TW'(i_setpoint);
    end

    // Next-state logic of the control and accumulator registers.
    always_comb begin
        n_swpos   = r_swpos;
        n_sfill   = r_sfill;
        n_stotal  = r_stotal;
        n_lwpos   = r_lwpos;
        n_lfill   = r_lfill;
        n_ltotal  = r_ltotal;
        n_lmean   = r_lmean;
        n_reached = r_reached;
        n_relay   = r_relay;
        n_tick    = r_tick;
        n_taken   = r_taken;
        if (i_cmd.tick && (r_tick != otc_pkg::TICK_MAX)) begin
            n_tick = r_tick + 1'b1;
        end
        if (i_cmd.sample_load) begin
            n_taken = 1'b0;
        end
        if (i_cmd.short_upd) begin
            n_stotal = r_stotal + s_new_ext - s_old_ext;
            n_swpos  = (r_swpos == SAW'(SHORT_DEPTH - 1)) ? '0 : r_swpos + 1'b1;
            if (r_sfill != SFW'(SHORT_DEPTH)) begin
                n_sfill = r_sfill + 1'b1;
            end
        end
        if (i_cmd.temp_upd) begin
            if (temp_val >= sp_ext) begin
                n_reached = 1'b1;
            end
            n_relay = (temp_val <= sp_ext);
        end
        if (i_cmd.long_upd) begin
            n_tick   = '0;
            n_taken  = 1'b1;
            n_ltotal = r_ltotal + l_new_ext - l_old_ext;
            n_lwpos  = (r_lwpos == LAW'(LONG_DEPTH - 1)) ? '0 : r_lwpos + 1'b1;
            if (r_lfill != LFW'(LONG_DEPTH)) begin
                n_lfill = r_lfill + 1'b1;
            end
        end
        if (i_cmd.mean_upd) begin
            n_lmean = r_lneg ? MW'(-q_mean) : MW'(q_mean);
        end
    end

    // Model state is cleared at reset; the rings rely on the fill counts instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swpos   <= '0;
            r_sfill   <= '0;
            r_stotal  <= '0;
            r_lwpos   <= '0;
            r_lfill   <= '0;
            r_ltotal  <= '0;
            r_lmean   <= '0;
            r_reached <= 1'b0;
            r_relay   <= 1'b0;
            r_tick    <= '0;
            r_taken   <= 1'b0;
        end else begin
            r_swpos   <= n_swpos;
            r_sfill   <= n_sfill;
            r_stotal  <= n_stotal;
            r_lwpos   <= n_lwpos;
            r_lfill   <= n_lfill;
            r_ltotal  <= n_ltotal;
            r_lmean   <= n_lmean;
            r_reached <= n_reached;
            r_relay   <= n_relay;
            r_tick    <= n_tick;
            r_taken   <= n_taken;
        end
    end

    // Payload registers loaded on command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_load) begin
            r_sample <= sample_val;
        end
        if (i_cmd.sdiv_start) begin
            r_sneg <= r_stotal[STW-1];
        end
        if (i_cmd.ldiv_start) begin
            r_lneg <= r_ltotal[LTW-1];
        end
        if (i_cmd.temp_upd) begin
            r_temp <= temp_val;
        end
        if (i_cmd.out_load) begin
            r_out <= {r_taken, (r_lfill != '0), r_lmean, r_reached, r_relay, r_temp};
        end
    end

    // A long sample is due once the setpoint was reached and the interval has elapsed.
    assign o_sts.div_done = div_done;
    assign o_sts.long_go  = r_reached && (r_tick >= i_interval);
    assign o_result       = r_out;

endmodule

// ===== design/otc_ctrl.sv =====
// Thermostat controller: one-hot sequencer for the stream handshakes and datapath commands.
// Depends on otc_pkg for the command and status bundles.
module otc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_func,
    output logic          o_s_ready,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output otc_pkg::t_cmd o_cmd,
    input  otc_pkg::t_sts i_sts
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SSUM = 9'b000000010,
        ST_SST  = 9'b000000100,
        ST_SDIV = 9'b000001000,
        ST_DEC  = 9'b000010000,
        ST_LSUM = 9'b000100000,
        ST_LST  = 9'b001000000,
        ST_LDIV = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   accept;

    assign o_s_ready = (r_state == ST_IDLE);
    assign accept    = i_s_valid && o_s_ready;

    // Sequence of a reading: short ring update, short mean, optional long sample, result hand-off.
    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_ready;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_s_func == otc_pkg::FUNC_TICK) begin
                        o_cmd.tick = 1'b1;
                    end else begin
                        o_cmd.sample_load = 1'b1;
                        o_cmd.short_rd    = 1'b1;
                        n_state           = ST_SSUM;
                    end
                end
            end
            ST_SSUM: begin
                o_cmd.short_upd = 1'b1;
                n_state         = ST_SST;
            end
            ST_SST: begin
                o_cmd.sdiv_start = 1'b1;
                n_state          = ST_SDIV;
            end
            ST_SDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.temp_upd = 1'b1;
                    n_state        = ST_DEC;
                end
            end
            ST_DEC: begin
                if (i_sts.long_go) begin
                    o_cmd.long_rd = 1'b1;
                    n_state       = ST_LSUM;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_LSUM: begin
                o_cmd.long_upd = 1'b1;
                n_state        = ST_LST;
            end
            ST_LST: begin
                o_cmd.ldiv_start = 1'b1;
                n_state          = ST_LDIV;
            end
            ST_LDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.mean_upd = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            ST_OUT: begin
                // Wait until the output register is free, then load the result beat.
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

endmodule

// ===== design/oven_temperature_thermostat_core.sv =====
// Top level of the oven thermostat: configuration registers, controller and datapath.
// Depends on otc_pkg, otc_ctrl and otc_dp (which holds otc_ram and otc_div).
//
// Channel   | Kind          | Payload
// ----------+---------------+---------------------------------------------------------
// s_axis    | stream in     | tdata: raw_quarters; tuser: func (0 reading, 1 tick)
// m_axis    | stream out    | tdata: calibrated_degrees .. long_sample_taken
// apb       | register port | offset_quarters, setpoint_degrees, interval_ticks
//
// A reading passes through the short mean and, when a long sample is due, the long mean;
// the serial divider (numerator width NW, 21 at the default depths), shared by both means,
// computes each in turn. Reset clears the control and accumulator registers; the rings are
// not cleared, since the fill counts mask stale entries, so no clearing pass is needed.
// The input is taken only while the sequencer is idle; a result waiting in the output
// register does not block new beats until the next result is ready to be loaded.
module oven_temperature_thermostat_core #(
    parameter int SHORT_DEPTH = 8,
    parameter int LONG_DEPTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [otc_pkg::IN_W-1:0]      s_axis_tdata,   // [11:0] raw_quarters, [15:12] zero
    input  logic                          s_axis_tuser,   // [0] func
    // Output stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [otc_pkg::OUT_W-1:0]     m_axis_tdata,   // [11:0] calibrated_degrees,
                                                          // [12] relay_drive,
                                                          // [13] reached_flag,
                                                          // [29:14] long_mean_x16,
                                                          // [30] long_mean_valid,
                                                          // [31] long_sample_taken
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [otc_pkg::CFG_AW-1:0]    paddr,
    input  logic [otc_pkg::CFG_DW-1:0]    pwdata,
    output logic [otc_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);

    logic [otc_pkg::OFS_W-1:0] r_offset;
    logic [otc_pkg::SP_W-1:0]  r_setpoint;
    logic [otc_pkg::INT_W-1:0] r_interval;
    logic                      cfg_wr;
    logic [1:0]                cfg_idx;
    otc_pkg::t_cmd             cmd;
    otc_pkg::t_sts             sts;

    // Register writes complete in the access cycle; the port never stalls.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_setpoint <= '0;
            r_interval <= otc_pkg::INTERVAL_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                otc_pkg::REG_OFFSET:   r_offset   <= pwdata[otc_pkg::OFS_W-1:0];
                otc_pkg::REG_SETPOINT: r_setpoint <= pwdata[otc_pkg::SP_W-1:0];
                otc_pkg::REG_INTERVAL: r_interval <= pwdata[otc_pkg::INT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            otc_pkg::REG_OFFSET:   prdata = otc_pkg::CFG_DW'(r_offset);
            otc_pkg::REG_SETPOINT: prdata = otc_pkg::CFG_DW'(r_setpoint);
            otc_pkg::REG_INTERVAL: prdata = otc_pkg::CFG_DW'(r_interval);
            default:               prdata = '0;
        endcase
    end

    otc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_func  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    otc_dp #(.SHORT_DEPTH(SHORT_DEPTH), .LONG_DEPTH(LONG_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_raw      (s_axis_tdata[otc_pkg::RAW_W-1:0]),
        .i_offset   (r_offset),
        .i_setpoint (r_setpoint),
        .i_interval (r_interval),
        .o_result   (m_axis_tdata)
    );

    // A tick beat never produces a result on its own.
    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == otc_pkg::FUNC_TICK)
         && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("tick beat produced a result");

    // A reading occupies the sequencer, so the input cannot be taken on the next cycle.
    a_reading_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == otc_pkg::FUNC_READING))
        |=> !s_axis_tready)
        else $error("input ready right after a reading");

    // A long sample leaves the long ring non-empty.
    a_taken_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[31]) |-> m_axis_tdata[30])
        else $error("long sample taken without a valid long mean");

    // The relay is off only above the setpoint, which also sets the reached flag.
    a_relay_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[12]) |-> m_axis_tdata[13])
        else $error("relay off while setpoint never reached");

endmodule
